@@ rtl/jtms_pkg.sv @@
// Shared types, constants and register map for the joystick to menu steps block.
package jtms_pkg;

    // Default sample width of the converter inputs.
    localparam int SAMPLE_BITS_DEF = 12;

    // Register file geometry and register indexes.
    localparam int CFG_ADDR_W = 5;
    localparam int CFG_IDX_W  = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_X_ORIGIN      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_Y_ORIGIN      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_X_DEAD_RADIUS = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_Y_DEAD_RADIUS = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_THRESH   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE_HOLD = 3'd5;

    // Field widths.
    localparam int ORIGIN_W = 12;
    localparam int THR_W    = 15;
    localparam int CNT_W    = 4;
    localparam int MAP_W    = 9;
    localparam int LEVEL_W  = 16;

    // Reset values of the registers.
    localparam logic [ORIGIN_W-1:0] X_ORIGIN_RST = 12'd1735;
    localparam logic [ORIGIN_W-1:0] Y_ORIGIN_RST = 12'd1712;
    localparam logic [ORIGIN_W-1:0] X_DEAD_RST   = 12'd14;
    localparam logic [ORIGIN_W-1:0] Y_DEAD_RST   = 12'd12;
    localparam logic [THR_W-1:0]    THR_RST      = 15'd9000;
    localparam logic [CNT_W-1:0]    HOLD_RST     = 4'd2;

    // Per axis and per sign scale divisors.
    localparam int DIV_X_NEG = 19;
    localparam int DIV_X_POS = 22;
    localparam int DIV_Y_NEG = 18;
    localparam int DIV_Y_POS = 24;

    // Result word layout, lowest bit first.
    localparam int OUT_TDATA_W      = 32;
    localparam int OUT_MAPPED_X_LSB = 0;
    localparam int OUT_MAPPED_Y_LSB = 9;
    localparam int OUT_COUNT_LSB    = 18;
    localparam int OUT_ENTER_BIT    = 22;
    localparam int OUT_UP_BIT       = 23;
    localparam int OUT_DOWN_BIT     = 24;
    localparam int OUT_PLUS_BIT     = 25;
    localparam int OUT_MINUS_BIT    = 26;

    // Configuration register set.
    typedef struct packed {
        logic [ORIGIN_W-1:0] x_origin;
        logic [ORIGIN_W-1:0] y_origin;
        logic [ORIGIN_W-1:0] x_dead_radius;
        logic [ORIGIN_W-1:0] y_dead_radius;
        logic [THR_W-1:0]    step_threshold;
        logic [CNT_W-1:0]    debounce_hold;
    } cfg_t;

    // Crossing flags of one level accumulator.
    typedef struct packed {
        logic pos;
        logic neg;
    } step_t;

endpackage

@@ rtl/joystick_to_menu_steps.sv @@
// Top level: stream ports, three stage pipeline, button debounce and result register.
// Each input word passes the input word register, both axis stages and the result register.
// Throughput: one word per cycle; the pipeline holds only while the result register stalls.
// The stall path is the result register's ready, which gates every stage together.
// Reset: asynchronous, active low; clears valid bits, level accumulators, button state,
// and loads the configuration registers with their default values.
module joystick_to_menu_steps
#(
    parameter int SAMPLE_BITS = jtms_pkg::SAMPLE_BITS_DEF
)
(
    input  logic                                    clk,
    input  logic                                    rst_n,
    // APB-style configuration port.
    input  logic                                    psel,
    input  logic                                    penable,
    input  logic                                    pwrite,
    input  logic [jtms_pkg::CFG_ADDR_W-1:0]         paddr,
    input  logic [31:0]                             pwdata,
    output logic [31:0]                             prdata,
    output logic                                    pready,
    // Input stream.
    input  logic                                    s_tvalid,
    output logic                                    s_tready,
    // Fields from bit 0: raw_x, raw_y, pressed, zero fill.
    input  logic [((2*SAMPLE_BITS+8)/8)*8-1:0]      s_tdata,
    // Result stream.
    output logic                                    m_tvalid,
    input  logic                                    m_tready,
    // Fields from bit 0: mapped_x, mapped_y, button_count, enter_pulse,
    // step_up, step_down, step_plus, step_minus, zero fill.
    output logic [jtms_pkg::OUT_TDATA_W-1:0]        m_tdata
);

    localparam int DW = (SAMPLE_BITS > jtms_pkg::ORIGIN_W) ? SAMPLE_BITS : jtms_pkg::ORIGIN_W;
    localparam int QW = DW - 4;
    localparam int SW = 2 * QW + 1;

    jtms_pkg::cfg_t            cfg;
    logic                      adv;
    logic                      v0_reg;
    logic                      v1_reg;
    logic                      v2_reg;
    logic                      out_valid_reg;
    logic [SAMPLE_BITS-1:0]    raw_x_reg;
    logic [SAMPLE_BITS-1:0]    raw_y_reg;
    logic                      press0_reg;
    logic                      press1_reg;
    logic                      press2_reg;
    logic signed [QW:0]        ax_mapped;
    logic signed [QW:0]        ay_mapped;
    logic signed [SW-1:0]      ax_sq;
    logic signed [SW-1:0]      ay_sq;
    jtms_pkg::step_t           ud_step;
    jtms_pkg::step_t           pm_step;
    logic [jtms_pkg::CNT_W-1:0] hold_reg;
    logic [jtms_pkg::CNT_W-1:0] hold_next;
    logic                      full_reg;
    logic                      full_next;
    logic                      upd;
    logic [jtms_pkg::OUT_TDATA_W-1:0] out_data_reg;
    logic [jtms_pkg::OUT_TDATA_W-1:0] out_data_next;

    // The whole pipeline moves when the result register is free or being drained.
    assign adv      = !out_valid_reg || m_tready;
    assign s_tready = adv;
    assign upd      = adv && v2_reg;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    jtms_cfg u_cfg
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Stage valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg        <= 1'b0;
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            v0_reg        <= s_tvalid;
            v1_reg        <= v0_reg;
            v2_reg        <= v1_reg;
            out_valid_reg <= v2_reg;
        end
    end

    // Input word register and the button flag carried alongside the axis stages.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            raw_x_reg  <= s_tdata[SAMPLE_BITS-1:0];
            raw_y_reg  <= s_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];
            press0_reg <= s_tdata[2*SAMPLE_BITS];
            press1_reg <= press0_reg;
            press2_reg <= press1_reg;
        end
    end

    jtms_axis #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .DIV_NEG     (jtms_pkg::DIV_X_NEG),
        .DIV_POS     (jtms_pkg::DIV_X_POS)
    ) u_axis_x (
        .clk    (clk),
        .en     (adv),
        .raw    (raw_x_reg),
        .origin (cfg.x_origin),
        .dead   (cfg.x_dead_radius),
        .mapped (ay_mapped),
        .sq     (ay_sq)
    );

    jtms_axis #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .DIV_NEG     (jtms_pkg::DIV_Y_NEG),
        .DIV_POS     (jtms_pkg::DIV_Y_POS)
    ) u_axis_y (
        .clk    (clk),
        .en     (adv),
        .raw    (raw_y_reg),
        .origin (cfg.y_origin),
        .dead   (cfg.y_dead_radius),
        .mapped (ax_mapped),
        .sq     (ax_sq)
    );

    // Up-down level follows mapped_y, plus-minus level follows mapped_x.
    jtms_level #(.SQ_W (SW)) u_level_ud
    (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (upd),
        .sq    (ay_sq),
        .thr   (cfg.step_threshold),
        .step  (ud_step)
    );

    jtms_level #(.SQ_W (SW)) u_level_pm
    (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (upd),
        .sq    (ax_sq),
        .thr   (cfg.step_threshold),
        .step  (pm_step)
    );

    // Button debounce countdown and full hold edge detect.
    always_comb
    begin
        if (press2_reg)
        begin
            hold_next = cfg.debounce_hold;
        end
        else if (hold_reg != '0)
        begin
            hold_next = hold_reg - 1'b1;
        end
        else
        begin
            hold_next = hold_reg;
        end
        full_next = (hold_next == cfg.debounce_hold);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_reg <= '0;
            full_reg <= 1'b0;
        end
        else if (upd)
        begin
            hold_reg <= hold_next;
            full_reg <= full_next;
        end
    end

    // Result word packing.
    always_comb
    begin
        out_data_next = '0;
        out_data_next[jtms_pkg::OUT_MAPPED_X_LSB +: jtms_pkg::MAP_W] =
            ax_mapped[jtms_pkg::MAP_W-1:0];
        out_data_next[jtms_pkg::OUT_MAPPED_Y_LSB +: jtms_pkg::MAP_W] =
            ay_mapped[jtms_pkg::MAP_W-1:0];
        out_data_next[jtms_pkg::OUT_COUNT_LSB +: jtms_pkg::CNT_W] = hold_next;
        out_data_next[jtms_pkg::OUT_ENTER_BIT] = full_next && !full_reg;
        out_data_next[jtms_pkg::OUT_UP_BIT]    = ud_step.pos;
        out_data_next[jtms_pkg::OUT_DOWN_BIT]  = ud_step.neg;
        out_data_next[jtms_pkg::OUT_PLUS_BIT]  = pm_step.pos;
        out_data_next[jtms_pkg::OUT_MINUS_BIT] = pm_step.neg;
    end

    always_ff @(posedge clk)
    begin
        if (upd)
        begin
            out_data_reg <= out_data_next;
        end
    end

endmodule

@@ rtl/jtms_cfg.sv @@
// Configuration register file with an APB-style access port.
module jtms_cfg
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [jtms_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready,
    output jtms_pkg::cfg_t                  cfg
);

    jtms_pkg::cfg_t                 cfg_reg;
    logic [jtms_pkg::CFG_IDX_W-1:0] idx;
    logic                           wr_en;

    assign pready = 1'b1;
    assign idx    = paddr[jtms_pkg::CFG_ADDR_W-1:2];
    assign wr_en  = psel && penable && pwrite;
    assign cfg    = cfg_reg;

    // Register writes on the access cycle.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.x_origin       <= jtms_pkg::X_ORIGIN_RST;
            cfg_reg.y_origin       <= jtms_pkg::Y_ORIGIN_RST;
            cfg_reg.x_dead_radius  <= jtms_pkg::X_DEAD_RST;
            cfg_reg.y_dead_radius  <= jtms_pkg::Y_DEAD_RST;
            cfg_reg.step_threshold <= jtms_pkg::THR_RST;
            cfg_reg.debounce_hold  <= jtms_pkg::HOLD_RST;
        end
        else if (wr_en)
        begin
            unique case (idx)
                jtms_pkg::CFG_X_ORIGIN:
                    cfg_reg.x_origin <= pwdata[jtms_pkg::ORIGIN_W-1:0];
                jtms_pkg::CFG_Y_ORIGIN:
                    cfg_reg.y_origin <= pwdata[jtms_pkg::ORIGIN_W-1:0];
                jtms_pkg::CFG_X_DEAD_RADIUS:
                    cfg_reg.x_dead_radius <= pwdata[jtms_pkg::ORIGIN_W-1:0];
                jtms_pkg::CFG_Y_DEAD_RADIUS:
                    cfg_reg.y_dead_radius <= pwdata[jtms_pkg::ORIGIN_W-1:0];
                jtms_pkg::CFG_STEP_THRESH:
                    cfg_reg.step_threshold <= pwdata[jtms_pkg::THR_W-1:0];
                jtms_pkg::CFG_DEBOUNCE_HOLD:
                    cfg_reg.debounce_hold <= pwdata[jtms_pkg::CNT_W-1:0];
                default:
                    cfg_reg <= cfg_reg;
            endcase
        end
    end

    // Read back mux.
    always_comb
    begin
        unique case (idx)
            jtms_pkg::CFG_X_ORIGIN:      prdata = 32'(cfg_reg.x_origin);
            jtms_pkg::CFG_Y_ORIGIN:      prdata = 32'(cfg_reg.y_origin);
            jtms_pkg::CFG_X_DEAD_RADIUS: prdata = 32'(cfg_reg.x_dead_radius);
            jtms_pkg::CFG_Y_DEAD_RADIUS: prdata = 32'(cfg_reg.y_dead_radius);
            jtms_pkg::CFG_STEP_THRESH:   prdata = 32'(cfg_reg.step_threshold);
            jtms_pkg::CFG_DEBOUNCE_HOLD: prdata = 32'(cfg_reg.debounce_hold);
            default:                     prdata = 32'd0;
        endcase
    end

endmodule

@@ rtl/jtms_axis.sv @@
// One axis: origin removal, dead zone, constant division and signed square.
module jtms_axis
#(
    parameter int SAMPLE_BITS = jtms_pkg::SAMPLE_BITS_DEF,
    parameter int DIV_NEG     = jtms_pkg::DIV_X_NEG,
    parameter int DIV_POS     = jtms_pkg::DIV_X_POS,
    localparam int DW         = (SAMPLE_BITS > jtms_pkg::ORIGIN_W) ? SAMPLE_BITS
                                                                   : jtms_pkg::ORIGIN_W,
    localparam int QW         = DW - 4,
    localparam int SW         = 2 * QW + 1
)
(
    input  logic                            clk,
    input  logic                            en,
    input  logic [SAMPLE_BITS-1:0]          raw,
    input  logic [jtms_pkg::ORIGIN_W-1:0]   origin,
    input  logic [jtms_pkg::ORIGIN_W-1:0]   dead,
    output logic signed [QW:0]              mapped,
    output logic signed [SW-1:0]            sq
);

    // Reciprocal scaling: floor(m * R / 2^K) equals floor(m / D) for all m below 2^DW.
    localparam int K  = DW + 5;
    localparam int RW = DW + 1;
    localparam int PW = DW + RW;
    localparam logic [RW-1:0] R_NEG = RW'(((64'd1 << K) + DIV_NEG - 1) / DIV_NEG);
    localparam logic [RW-1:0] R_POS = RW'(((64'd1 << K) + DIV_POS - 1) / DIV_POS);

    logic signed [DW:0]  defl;
    logic                defl_neg;
    logic [DW-1:0]       mag;
    logic [PW-1:0]       prod;
    logic [PW-1:0]       prod_reg;
    logic                neg_reg;
    logic                zero_reg;
    logic [QW-1:0]       quot;
    logic signed [QW:0]  mapped_next;
    logic [2*QW-1:0]     sq_mag;
    logic signed [SW-1:0] sq_next;
    logic signed [QW:0]  mapped_reg;
    logic signed [SW-1:0] sq_reg;

    // First stage: deflection, dead zone test and reciprocal multiply.
    always_comb
    begin
        defl     = $signed({1'b0, DW'(raw)}) - $signed({1'b0, DW'(origin)});
        defl_neg = defl[DW];
        mag      = defl_neg ? DW'(-defl) : defl[DW-1:0];
        prod     = PW'(mag) * PW'(defl_neg ? R_NEG : R_POS);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= prod;
            neg_reg  <= defl_neg;
            zero_reg <= (mag <= DW'(dead));
        end
    end

    // Second stage: quotient, negated mapping and signed square.
    always_comb
    begin
        quot        = zero_reg ? '0 : prod_reg[K +: QW];
        mapped_next = neg_reg ? $signed({1'b0, quot}) : -$signed({1'b0, quot});
        sq_mag      = (2*QW)'(quot) * (2*QW)'(quot);
        sq_next     = neg_reg ? $signed({1'b0, sq_mag}) : -$signed({1'b0, sq_mag});
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mapped_reg <= mapped_next;
            sq_reg     <= sq_next;
        end
    end

    assign mapped = mapped_reg;
    assign sq     = sq_reg;

endmodule

@@ rtl/jtms_level.sv @@
// Level accumulator of one menu axis with threshold crossing detection.
module jtms_level
#(
    parameter int SQ_W = 17
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         en,
    input  logic signed [SQ_W-1:0]       sq,
    input  logic [jtms_pkg::THR_W-1:0]   thr,
    output jtms_pkg::step_t              step
);

    localparam int SUM_W = ((SQ_W > jtms_pkg::LEVEL_W) ? SQ_W : jtms_pkg::LEVEL_W) + 1;

    logic signed [jtms_pkg::LEVEL_W-1:0] level_reg;
    logic signed [jtms_pkg::LEVEL_W-1:0] level_next;
    logic signed [SUM_W-1:0]             sum;
    logic signed [SUM_W-1:0]             lim;

    // Full width sum so the compare never sees a wrapped level.
    always_comb
    begin
        sum        = SUM_W'(level_reg) + SUM_W'(sq);
        lim        = $signed(SUM_W'(thr));
        step.pos   = sum > lim;
        step.neg   = sum < -lim;
        level_next = (step.pos || step.neg) ? '0 : sum[jtms_pkg::LEVEL_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg <= '0;
        end
        else if (en)
        begin
            level_reg <= level_next;
        end
    end

endmodule

@@ rtl/jtms_checker.sv @@
// Port level checks for the joystick to menu steps block, bound to its top level.
module jtms_checker
(
    input logic                                 clk,
    input logic                                 rst_n,
    input logic                                 s_tready,
    input logic                                 m_tvalid,
    input logic                                 m_tready,
    input logic [jtms_pkg::OUT_TDATA_W-1:0]     m_tdata
);

    // A stalled result word holds.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result word changed while stalled");

    // The input side is never held off while the result side takes words.
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        m_tready |-> s_tready)
        else $error("input stalled while result side is ready");

    // One accumulator cannot cross both thresholds at once.
    a_ud_excl: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(m_tdata[jtms_pkg::OUT_UP_BIT] && m_tdata[jtms_pkg::OUT_DOWN_BIT]))
        else $error("step up and step down together");

    a_pm_excl: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(m_tdata[jtms_pkg::OUT_PLUS_BIT] && m_tdata[jtms_pkg::OUT_MINUS_BIT]))
        else $error("step plus and step minus together");

endmodule

bind joystick_to_menu_steps jtms_checker u_jtms_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

@@ test/joystick_to_menu_steps_test.sv @@
`timescale 1ns / 100ps
// Self-checking stream testbench for the joystick to menu steps block.
module joystick_to_menu_steps_test;

    localparam int SBITS        = jtms_pkg::SAMPLE_BITS_DEF;
    localparam int IN_W         = ((2*SBITS+8)/8)*8;
    localparam int ORG_W        = jtms_pkg::ORIGIN_W;
    localparam int THR_BITS     = jtms_pkg::THR_W;
    localparam int CNT_BITS     = jtms_pkg::CNT_W;
    localparam int MAP_BITS     = jtms_pkg::MAP_W;
    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 8;
    localparam int CHUNK_WORDS  = 50;
    localparam int CHUNKS       = 4;
    localparam int SAMPLE_TOP   = (1 << SBITS) - 1;

    // Register slots past the end of the map; writes there must be ignored.
    localparam logic [jtms_pkg::CFG_IDX_W-1:0] CFG_SPARE_A = 3'd6;
    localparam logic [jtms_pkg::CFG_IDX_W-1:0] CFG_SPARE_B = 3'd7;

    // One predicted result word, field by field.
    typedef struct packed {
        logic [MAP_BITS-1:0] mapped_x;
        logic [MAP_BITS-1:0] mapped_y;
        logic [CNT_BITS-1:0] button_count;
        logic                enter_pulse;
        logic                step_up;
        logic                step_down;
        logic                step_plus;
        logic                step_minus;
    } menu_result_t;

    logic                                clk     = 1'b0;
    logic                                rst_n   = 1'b0;
    logic                                psel    = 1'b0;
    logic                                penable = 1'b0;
    logic                                pwrite  = 1'b0;
    logic [jtms_pkg::CFG_ADDR_W-1:0]     paddr   = '0;
    logic [31:0]                         pwdata  = '0;
    logic [31:0]                         prdata;
    logic                                pready;
    logic                                s_tvalid = 1'b0;
    logic                                s_tready;
    logic [IN_W-1:0]                     s_tdata  = '0;
    logic                                m_tvalid;
    logic                                m_tready = 1'b0;
    logic [jtms_pkg::OUT_TDATA_W-1:0]    m_tdata;

    // Predictor copy of the configuration and the block state.
    jtms_pkg::cfg_t      cfg_model;
    int                  up_down_acc;
    int                  plus_minus_acc;
    logic [CNT_BITS-1:0] hold_cnt;
    logic                hold_full_prev;

    menu_result_t expected_results[$];
    menu_result_t front_result;

    int send_idle_pct = 38;
    int recv_idle_pct = 49;
    int errors         = 0;
    int words_sent     = 0;
    int words_checked  = 0;
    int settings_used  = 0;
    int steps_seen     = 0;
    int enters_seen    = 0;

    joystick_to_menu_steps uut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #6 clk = ~clk;

    // Result side back-pressure, redrawn every cycle.
    always @(negedge clk)
    begin
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Removes the origin, applies the dead zone and divides toward zero.
    function automatic int scale_axis(input logic [SBITS-1:0] raw,
                                      input logic [ORG_W-1:0] origin,
                                      input logic [ORG_W-1:0] dead,
                                      input int neg_div, input int pos_div);
        int d;
        int mag;
        d   = int'(raw) - int'(origin);
        mag = (d < 0) ? -d : d;
        if (mag <= int'(dead))
            return 0;
        return (d < 0) ? d / neg_div : d / pos_div;
    endfunction

    // Adds the signed square to a level and reports a threshold crossing.
    task automatic advance_level(inout int level, input int v, output logic up,
                                 output logic dn);
        longint sum;
        longint lim;
        sum   = longint'(level) + longint'((v < 0) ? -v : v) * longint'(v);
        lim   = longint'(cfg_model.step_threshold);
        up    = (sum > lim);
        dn    = !up && (sum < -lim);
        level = (up || dn) ? 0 : int'(sum);
    endtask

    // Works out the result word of one sample tick and advances the state.
    task automatic predict_tick(input logic [SBITS-1:0] rx, input logic [SBITS-1:0] ry,
                                input logic press, output menu_result_t r);
        int   sx;
        int   sy;
        int   mx;
        int   my;
        logic up;
        logic dn;
        logic full;
        sx = scale_axis(rx, cfg_model.x_origin, cfg_model.x_dead_radius,
                        jtms_pkg::DIV_X_NEG, jtms_pkg::DIV_X_POS);
        sy = scale_axis(ry, cfg_model.y_origin, cfg_model.y_dead_radius,
                        jtms_pkg::DIV_Y_NEG, jtms_pkg::DIV_Y_POS);
        // Axes are swapped and negated.
        mx = -sy;
        my = -sx;
        r.mapped_x = mx[MAP_BITS-1:0];
        r.mapped_y = my[MAP_BITS-1:0];
        advance_level(up_down_acc, my, up, dn);
        r.step_up   = up;
        r.step_down = dn;
        advance_level(plus_minus_acc, mx, up, dn);
        r.step_plus  = up;
        r.step_minus = dn;
        // Debounce countdown and enter edge.
        if (press)
            hold_cnt = cfg_model.debounce_hold;
        else if (hold_cnt != 0)
            hold_cnt = hold_cnt - 1'b1;
        full             = (hold_cnt == cfg_model.debounce_hold);
        r.enter_pulse    = full && !hold_full_prev;
        hold_full_prev   = full;
        r.button_count   = hold_cnt;
    endtask

    // Offers one sample word, waits for the handshake and records its result.
    task automatic send_word(input logic [SBITS-1:0] rx, input logic [SBITS-1:0] ry,
                             input logic press);
        logic [IN_W-1:0] word;
        menu_result_t    r;
        word                   = '0;
        word[SBITS-1:0]        = rx;
        word[2*SBITS-1:SBITS]  = ry;
        word[2*SBITS]          = press;
        while ($urandom_range(99) < send_idle_pct)
        begin
            @(negedge clk);
            s_tvalid <= 1'b0;
        end
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tdata  <= word;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        predict_tick(rx, ry, press, r);
        expected_results.push_back(r);
        words_sent++;
        steps_seen  += int'(r.step_up) + int'(r.step_down) + int'(r.step_plus)
                       + int'(r.step_minus);
        enters_seen += int'(r.enter_pulse);
    endtask

    // Holds the sender back until every pending result has been seen.
    task automatic wait_drained();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // One register write: setup cycle, then access cycle.
    task automatic cfg_write(input logic [jtms_pkg::CFG_IDX_W-1:0] idx,
                             input logic [31:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        case (idx)
            jtms_pkg::CFG_X_ORIGIN:
                cfg_model.x_origin       = value[ORG_W-1:0];
            jtms_pkg::CFG_Y_ORIGIN:
                cfg_model.y_origin       = value[ORG_W-1:0];
            jtms_pkg::CFG_X_DEAD_RADIUS:
                cfg_model.x_dead_radius  = value[ORG_W-1:0];
            jtms_pkg::CFG_Y_DEAD_RADIUS:
                cfg_model.y_dead_radius  = value[ORG_W-1:0];
            jtms_pkg::CFG_STEP_THRESH:
                cfg_model.step_threshold = value[THR_BITS-1:0];
            jtms_pkg::CFG_DEBOUNCE_HOLD:
                cfg_model.debounce_hold  = value[CNT_BITS-1:0];
            default: ;
        endcase
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic cfg_set_all(input logic [ORG_W-1:0] xo, input logic [ORG_W-1:0] yo,
                               input logic [ORG_W-1:0] xd, input logic [ORG_W-1:0] yd,
                               input logic [THR_BITS-1:0] thr,
                               input logic [CNT_BITS-1:0] hold);
        cfg_write(jtms_pkg::CFG_X_ORIGIN, 32'(xo));
        cfg_write(jtms_pkg::CFG_Y_ORIGIN, 32'(yo));
        cfg_write(jtms_pkg::CFG_X_DEAD_RADIUS, 32'(xd));
        cfg_write(jtms_pkg::CFG_Y_DEAD_RADIUS, 32'(yd));
        cfg_write(jtms_pkg::CFG_STEP_THRESH, 32'(thr));
        cfg_write(jtms_pkg::CFG_DEBOUNCE_HOLD, 32'(hold));
        settings_used++;
    endtask

    // Sample picker: near the centre, on the dead zone edge, anywhere, or rail to rail.
    function automatic logic [SBITS-1:0] pick_sample(input logic [ORG_W-1:0] origin,
                                                     input logic [ORG_W-1:0] dead);
        int v;
        int span;
        span = int'(dead) + 1;
        case ($urandom_range(4))
            0, 1:    v = int'(origin) + int'($urandom_range(2*span + 400)) - (span + 200);
            2:       v = int'($urandom_range(SAMPLE_TOP));
            3:       v = $urandom_range(1) ? 0 : SAMPLE_TOP;
            default: v = int'(origin) + ($urandom_range(1) ? 1 : -1)
                         * (int'(dead) + int'($urandom_range(1)));
        endcase
        if (v < 0)
            v = 0;
        if (v > SAMPLE_TOP)
            v = SAMPLE_TOP;
        return v[SBITS-1:0];
    endfunction

    // Compares one field of a result word.
    task automatic check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            errors++;
        end
    endtask

    // Result checker: every accepted word against the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_results.size() == 0)
            begin
                $error("result word 0x%08h arrived with nothing pending", m_tdata);
                errors++;
            end
            else
            begin
                front_result = expected_results.pop_front();
                words_checked++;
                check_field("mapped_x", int'($signed(front_result.mapped_x)),
                            int'($signed(m_tdata[jtms_pkg::OUT_MAPPED_X_LSB +: MAP_BITS])));
                check_field("mapped_y", int'($signed(front_result.mapped_y)),
                            int'($signed(m_tdata[jtms_pkg::OUT_MAPPED_Y_LSB +: MAP_BITS])));
                check_field("button_count", int'(front_result.button_count),
                            int'(m_tdata[jtms_pkg::OUT_COUNT_LSB +: CNT_BITS]));
                check_field("enter_pulse", int'(front_result.enter_pulse),
                            int'(m_tdata[jtms_pkg::OUT_ENTER_BIT]));
                check_field("step_up", int'(front_result.step_up),
                            int'(m_tdata[jtms_pkg::OUT_UP_BIT]));
                check_field("step_down", int'(front_result.step_down),
                            int'(m_tdata[jtms_pkg::OUT_DOWN_BIT]));
                check_field("step_plus", int'(front_result.step_plus),
                            int'(m_tdata[jtms_pkg::OUT_PLUS_BIT]));
                check_field("step_minus", int'(front_result.step_minus),
                            int'(m_tdata[jtms_pkg::OUT_MINUS_BIT]));
            end
        end
    end

    // Watchdog: ends the run after a long stretch with no handshake at all.
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
                quiet = 0;
            else
                quiet++;
        end
        $display("Watchdog: no handshake for %0d cycles", STALL_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Reset settings: centre, dead zone edges, both rails and alternating bit patterns.
    task automatic test_default_settings();
        send_word(12'd1735, 12'd1712, 1'b0);
        send_word(12'd1749, 12'd1700, 1'b0);
        send_word(12'd1750, 12'd1725, 1'b1);
        send_word(12'd1720, 12'd1699, 1'b1);
        send_word(12'd0, 12'd0, 1'b1);
        send_word(12'd4095, 12'd4095, 1'b0);
        send_word(12'd0, 12'd4095, 1'b0);
        send_word(12'd4095, 12'd0, 1'b0);
        send_word(12'h555, 12'haaa, 1'b1);
        send_word(12'haaa, 12'h555, 1'b0);
    endtask

    // Register extremes, a zero debounce hold, thresholds at both ends and spare slots.
    task automatic test_config_extremes();
        wait_drained();
        cfg_set_all(12'd0, 12'd0, 12'd0, 12'd0, 15'd0, 4'd0);
        send_word(12'd0, 12'd0, 1'b1);
        send_word(12'd1, 12'd1, 1'b0);
        send_word(12'd4095, 12'd4095, 1'b0);
        send_word(12'd2048, 12'd2048, 1'b1);
        wait_drained();
        cfg_set_all(12'd4095, 12'd4095, 12'd4095, 12'd4095, 15'd32767, 4'd15);
        send_word(12'd0, 12'd0, 1'b1);
        send_word(12'd4095, 12'd4095, 1'b0);
        send_word(12'd2000, 12'd100, 1'b0);
        wait_drained();
        cfg_set_all(12'd4095, 12'd4095, 12'd0, 12'd0, 15'd30000, 4'd15);
        cfg_write(CFG_SPARE_A, $urandom());
        cfg_write(CFG_SPARE_B, $urandom());
        send_word(12'd0, 12'd0, 1'b1);
        send_word(12'd0, 12'd0, 1'b0);
        send_word(12'd0, 12'd0, 1'b0);
        send_word(12'd4095, 12'd0, 1'b0);
    endtask

    // Random settings per chunk, random samples and button runs.
    task automatic test_random_phase(input int s_pct, input int r_pct);
        int                  chunk;
        int                  n;
        logic                press;
        logic [ORG_W-1:0]    xo;
        logic [ORG_W-1:0]    yo;
        logic [ORG_W-1:0]    xd;
        logic [ORG_W-1:0]    yd;
        logic [THR_BITS-1:0] thr;
        logic [CNT_BITS-1:0] hold;
        send_idle_pct = s_pct;
        recv_idle_pct = r_pct;
        press = 1'b0;
        for (chunk = 0; chunk < CHUNKS; chunk++)
        begin
            wait_drained();
            xo = ORG_W'(($urandom_range(3) == 0) ? $urandom_range(4095)
                                                  : $urandom_range(2700, 1400));
            yo = ORG_W'(($urandom_range(3) == 0) ? $urandom_range(4095)
                                                  : $urandom_range(2700, 1400));
            xd = ORG_W'(($urandom_range(4) == 0) ? $urandom_range(600) : $urandom_range(60));
            yd = ORG_W'(($urandom_range(4) == 0) ? $urandom_range(600) : $urandom_range(60));
            case ($urandom_range(3))
                0:       thr = THR_BITS'($urandom_range(2000));
                1:       thr = THR_BITS'($urandom_range(30000));
                2:       thr = THR_BITS'($urandom_range(12000, 3000));
                default: thr = $urandom_range(1) ? 15'd32767 : 15'd0;
            endcase
            hold = CNT_BITS'($urandom_range(15));
            cfg_set_all(xo, yo, xd, yd, thr, hold);
            for (n = 0; n < CHUNK_WORDS; n++)
            begin
                if ($urandom_range(4) == 0)
                    press = !press;
                send_word(pick_sample(cfg_model.x_origin, cfg_model.x_dead_radius),
                          pick_sample(cfg_model.y_origin, cfg_model.y_dead_radius), press);
            end
        end
    endtask

    initial
    begin
        cfg_model.x_origin       = jtms_pkg::X_ORIGIN_RST;
        cfg_model.y_origin       = jtms_pkg::Y_ORIGIN_RST;
        cfg_model.x_dead_radius  = jtms_pkg::X_DEAD_RST;
        cfg_model.y_dead_radius  = jtms_pkg::Y_DEAD_RST;
        cfg_model.step_threshold = jtms_pkg::THR_RST;
        cfg_model.debounce_hold  = jtms_pkg::HOLD_RST;
        up_down_acc    = 0;
        plus_minus_acc = 0;
        hold_cnt       = '0;
        hold_full_prev = 1'b0;

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_default_settings();
        test_config_extremes();
        test_random_phase(38, 49);
        test_random_phase(49, 38);
        test_random_phase(0, 0);
        wait_drained();

        $display("Run covered %0d sample words and %0d checked results over %0d settings.",
                 words_sent, words_checked, settings_used);
        $display("Predicted %0d step pulses and %0d enter pulses.", steps_seen, enters_seen);
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
